>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the chunk hasher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CDCH_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CDCH_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/cdch_pkg.sv
// ----------------------------------------------------------------------------
// Chunk hasher package
// Types, constants and the FNV-1 step shared by the chunk hasher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdch_pkg;

    // Default configuration of the rolling hash and the skip window.
    localparam int unsigned DEF_WINDOW_LEN      = 7;
    localparam int unsigned DEF_TRIGGER_MODULUS = 256;
    localparam int unsigned DEF_SKIP_COUNT      = 64;

    // Shift of the shift-xor part of the rolling hash.
    localparam int unsigned SHIFT_STEP = 5;

    // FNV-1 64-bit offset basis.
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    // Result queue geometry.
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // One result word.
    typedef struct packed {
        logic [63:0] chunk_hash;
        logic        packet_done;
    } result_t;

    // Control of the rolling hash unit for one byte.
    typedef struct packed {
        logic roll;
        logic clear;
    } roll_ctrl_t;

    // One FNV-1 step: multiply by the 64-bit prime 2^40 + 0x1b3, then xor.
    // The prime is sparse, so the product is a sum of shifted copies.
    function automatic logic [63:0] fnv_step(input logic [63:0] acc,
                                             input logic [7:0]  b);
        logic [63:0] prod;
        prod = acc + (acc << 1) + (acc << 4) + (acc << 5) + (acc << 7)
             + (acc << 8) + (acc << 40);
        return prod ^ {56'd0, b};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cdch_roll.sv
// ----------------------------------------------------------------------------
// Rolling hash unit
// Window sum, weighted sum and shift-xor word over the last rolled bytes,
// with the chunk boundary test against the trigger modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module cdch_roll
    import cdch_pkg::*;
#(
    parameter int unsigned WINDOW_LEN      = DEF_WINDOW_LEN,
    parameter int unsigned TRIGGER_MODULUS = DEF_TRIGGER_MODULUS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire roll_ctrl_t ctrl,
    input  wire logic [7:0] data_byte,
    output logic            trigger
);

    localparam int unsigned MUL_W = 8 + $clog2(WINDOW_LEN + 1);
    localparam int unsigned RES_W = $clog2(TRIGGER_MODULUS);
    localparam int unsigned SUM_W = RES_W + 2;

    // A sum of four residues is below four times the modulus, so the hash
    // hits when that sum is one below one, two or three times the modulus.
    localparam logic [SUM_W-1:0] HIT_1 = SUM_W'(TRIGGER_MODULUS - 1);
    localparam logic [SUM_W-1:0] HIT_2 = SUM_W'(2 * TRIGGER_MODULUS - 1);
    localparam logic [SUM_W-1:0] HIT_3 = SUM_W'(3 * TRIGGER_MODULUS - 1);

    logic [7:0]       win_reg  [WINDOW_LEN];
    logic [7:0]       win_next [WINDOW_LEN];
    logic [31:0]      wsum_reg, wsum_next;
    logic [31:0]      wgt_reg, wgt_next;
    logic [31:0]      sx_reg, sx_next;

    logic [MUL_W-1:0] byte_mul;
    logic [31:0]      wsum_roll, wgt_roll, sx_roll, hash_val;
    logic [RES_W-1:0] res_tbl [4][256];
    logic [SUM_W-1:0] res_sum;

    // Residue tables: entry x of lane j is (x * 2^(8j)) mod the modulus.
    for (genvar j = 0; j < 4; j++) begin : g_lane
        for (genvar x = 0; x < 256; x++) begin : g_ent
            localparam longint RV = (longint'(x) << (8 * j)) % longint'(TRIGGER_MODULUS);
            assign res_tbl[j][x] = RES_W'(RV);
        end
    end

    // Rolled values for the incoming byte; the oldest byte sits at the end.
    always_comb
    begin
        byte_mul  = MUL_W'(WINDOW_LEN) * MUL_W'(data_byte);
        wsum_roll = wsum_reg + 32'(data_byte) - 32'(win_reg[WINDOW_LEN-1]);
        wgt_roll  = wgt_reg - wsum_reg + 32'(byte_mul);
        sx_roll   = (sx_reg << SHIFT_STEP) ^ 32'(data_byte);
        hash_val  = wsum_roll + wgt_roll + sx_roll;
    end

    // Boundary test on the hash, one residue per hash byte.
    always_comb
    begin
        res_sum = SUM_W'(res_tbl[0][hash_val[7:0]])
                + SUM_W'(res_tbl[1][hash_val[15:8]])
                + SUM_W'(res_tbl[2][hash_val[23:16]])
                + SUM_W'(res_tbl[3][hash_val[31:24]]);
        trigger = (res_sum == HIT_1) || (res_sum == HIT_2) || (res_sum == HIT_3);
    end

    // Next state: a packet end clears everything, a rolled byte shifts in.
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            win_next[i] = win_reg[i];
        end
        wsum_next = wsum_reg;
        wgt_next  = wgt_reg;
        sx_next   = sx_reg;
        if (ctrl.clear) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_next[i] = 8'd0;
            end
            wsum_next = 32'd0;
            wgt_next  = 32'd0;
            sx_next   = 32'd0;
        end else if (ctrl.roll) begin
            win_next[0] = data_byte;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                win_next[i] = win_reg[i-1];
            end
            wsum_next = wsum_roll;
            wgt_next  = wgt_roll;
            sx_next   = sx_roll;
        end
    end

    // Rolling state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= 8'd0;
            end
            wsum_reg <= 32'd0;
            wgt_reg  <= 32'd0;
            sx_reg   <= 32'd0;
        end else begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= win_next[i];
            end
            wsum_reg <= wsum_next;
            wgt_reg  <= wgt_next;
            sx_reg   <= sx_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cdch_out_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two result words per cycle and hands one
// word per cycle to the output channel while the channel is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cdch_out_fifo
    import cdch_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push0,
    input  wire logic    push1,
    input  wire result_t wdata0,
    input  wire result_t wdata1,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output logic [63:0]  chunk_hash,
    output logic         packet_done
);

    result_t              ent_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 pop;

    // Output side reads the oldest entry.
    assign out_valid   = (cnt_reg != '0);
    assign chunk_hash  = ent_reg[rd_ptr_reg].chunk_hash;
    assign packet_done = ent_reg[rd_ptr_reg].packet_done;
    assign pop         = out_valid && out_ready;

    // Room for two words, counted before this cycle's pop.
    assign room = (cnt_reg <= OUT_CNT_W'(OUT_DEPTH - 2));

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push0) + OUT_PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        cnt_next    = cnt_reg + OUT_CNT_W'(push0) + OUT_CNT_W'(push1) - OUT_CNT_W'(pop);
    end

    // Entry storage; the second word goes behind the first.
    always_ff @(posedge clk)
    begin
        if (push0) begin
            ent_reg[wr_ptr_reg] <= wdata0;
        end
        if (push1) begin
            ent_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= wdata1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `CDCH_ASSERT_ALWAYS(a_cnt_bound, clk, cnt_reg <= OUT_CNT_W'(OUT_DEPTH), "queue over depth")
    `CDCH_ASSERT(a_push_order, clk, rst_n, push1 |-> push0, "second word pushed without first")
    `CDCH_ASSERT(a_push_room, clk, rst_n, push0 |-> room, "word pushed without room")

endmodule

`default_nettype wire

>>> hw/rtl/content_defined_chunk_hasher.sv
// ----------------------------------------------------------------------------
// Content-defined chunk hasher
// Splits a packet byte stream into chunks at rolling hash boundaries and
// emits a 64-bit FNV-1 hash word for every chunk.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Word
//  input     in_valid/in_ready    data_byte, packet_length, last_byte
//  output    out_valid/out_ready  chunk_hash, packet_done
//
//  A byte is taken into an input register, processed from there when the
//  four-word result queue has room, and its result words are written into it.
//  One byte per cycle while the queue has room; a byte that closes two
//  chunks puts two words in the queue, which drains one word per cycle, so
//  the output port sets the rate; a result word is visible once queued.
//  Reset returns all state to the start of a packet; no clearing pass.
//  in_ready drops while the input register holds a byte and the queue has
//  room for fewer than two words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module content_defined_chunk_hasher
    import cdch_pkg::*;
#(
    parameter int unsigned WINDOW_LEN      = DEF_WINDOW_LEN,
    parameter int unsigned TRIGGER_MODULUS = DEF_TRIGGER_MODULUS,
    parameter int unsigned SKIP_COUNT      = DEF_SKIP_COUNT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] packet_length,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      chunk_hash,
    output logic             packet_done
);

    localparam int unsigned SKIP_W = $clog2(SKIP_COUNT + 2);

    logic              stage_valid_reg, stage_valid_next;
    logic [7:0]        stage_byte_reg;
    logic [15:0]       stage_len_reg;
    logic              stage_last_reg;
    logic              stage_fire;
    logic              in_fire;

    logic [63:0]       acc_reg, acc_next;
    logic [15:0]       pos_reg, pos_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;

    logic [63:0]       acc_step;
    roll_ctrl_t        roll_ctrl;
    logic              trigger;
    logic              hit;
    logic              skip_fits;
    logic              room;
    logic              push0, push1;
    result_t           wdata0, wdata1;
    logic              pkt_start_state;

    // Input register handshake.
    assign stage_fire       = stage_valid_reg && room;
    assign in_ready         = !stage_valid_reg || stage_fire;
    assign in_fire          = in_valid && in_ready;
    assign stage_valid_next = in_fire || (stage_valid_reg && !stage_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            stage_byte_reg <= data_byte;
            stage_len_reg  <= packet_length;
            stage_last_reg <= last_byte;
        end
    end

    // Rolling hash: bytes inside a skip stay out of it.
    always_comb
    begin
        roll_ctrl.roll  = stage_fire && (skip_reg == '0);
        roll_ctrl.clear = stage_fire && stage_last_reg;
    end

    cdch_roll #(
        .WINDOW_LEN      (WINDOW_LEN),
        .TRIGGER_MODULUS (TRIGGER_MODULUS)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (roll_ctrl),
        .data_byte (stage_byte_reg),
        .trigger   (trigger)
    );

    // Chunk boundary and skip decision.
    always_comb
    begin
        acc_step  = fnv_step(acc_reg, stage_byte_reg);
        hit       = roll_ctrl.roll && trigger;
        skip_fits = ({1'b0, pos_reg} + 17'(SKIP_COUNT)) < {1'b0, stage_len_reg};
    end

    // Result words: a boundary word comes before the packet end word.
    always_comb
    begin
        push0              = stage_fire && (hit || stage_last_reg);
        push1              = stage_fire && hit && stage_last_reg;
        wdata0.chunk_hash  = acc_step;
        wdata0.packet_done = !hit;
        wdata1.chunk_hash  = FNV_BASIS;
        wdata1.packet_done = 1'b1;
    end

    // Chunk accumulator, byte position and skip counter.
    always_comb
    begin
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        skip_next = skip_reg;
        if (stage_fire) begin
            if (hit || stage_last_reg) begin
                acc_next = FNV_BASIS;
            end else begin
                acc_next = acc_step;
            end
            if (stage_last_reg) begin
                pos_next  = 16'd0;
                skip_next = '0;
            end else begin
                pos_next = pos_reg + 16'd1;
                if (skip_reg != '0) begin
                    skip_next = skip_reg - SKIP_W'(1);
                end else if (hit && skip_fits) begin
                    skip_next = SKIP_W'(SKIP_COUNT);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg  <= FNV_BASIS;
            pos_reg  <= 16'd0;
            skip_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            skip_reg <= skip_next;
        end
    end

    cdch_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push0       (push0),
        .push1       (push1),
        .wdata0      (wdata0),
        .wdata1      (wdata1),
        .room        (room),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .chunk_hash  (chunk_hash),
        .packet_done (packet_done)
    );

    // Chunk state as it stands at the start of a packet.
    assign pkt_start_state = (pos_reg == '0) && (skip_reg == '0) && (acc_reg == FNV_BASIS);

    `CDCH_ASSERT(a_skip_bound, clk, rst_n, skip_reg <= SKIP_W'(SKIP_COUNT), "skip overrun")
    `CDCH_ASSERT(a_last_clears, clk, rst_n, roll_ctrl.clear |=> pkt_start_state, "state not cleared")
    `CDCH_ASSERT(a_hit_restarts, clk, rst_n, hit |=> (acc_reg == FNV_BASIS), "hash not restarted")

endmodule

`default_nettype wire
